### src/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int COUNTER_BITS_DEF = 16;

  localparam int CFG_BITS       = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int DECAY_BITS     = 15;
  localparam int DECAY_SHIFT    = 15;
  localparam int HITS_BITS      = 15;

  localparam logic [HITS_BITS-1:0] HITS_MAX = '1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_PERIODS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DECAY_FACTOR = 2'd2;

  localparam logic [CFG_BITS-1:0]   SHORT_PERIOD_RST = 16'd8;
  localparam logic [CFG_BITS-1:0]   HOLD_PERIODS_RST = 16'd8;
  localparam logic [DECAY_BITS-1:0] DECAY_FACTOR_RST = 15'd29491;

  typedef struct packed {
    logic accept;
    logic eob;
    logic publish;
  } lane_ctl_t;

endpackage

### src/spm_lane.sv
`timescale 1ns / 1ps

module spm_lane #(
  parameter int SAMPLE_BITS  = spm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNTER_BITS = spm_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spm_pkg::lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic [spm_pkg::DECAY_BITS-1:0]      decay_factor,
  input  logic [spm_pkg::CFG_BITS-1:0]        hold_periods,
  input  logic [COUNTER_BITS-1:0]             hold_in,
  output logic [COUNTER_BITS-1:0]             hold_out,
  output logic [SAMPLE_BITS-2:0]              short_nxt,
  output logic [SAMPLE_BITS-2:0]              long_nxt,
  output logic [SAMPLE_BITS-2:0]              max_nxt,
  output logic [spm_pkg::HITS_BITS-1:0]       hits_nxt
);

  localparam int LEVEL_BITS = SAMPLE_BITS - 1;
  localparam int PROD_BITS  = LEVEL_BITS + spm_pkg::DECAY_BITS;
  localparam int CMP_BITS   = (COUNTER_BITS > spm_pkg::CFG_BITS) ? COUNTER_BITS
                                                                 : spm_pkg::CFG_BITS;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  logic [LEVEL_BITS-1:0]         buffer_peak_r, buffer_peak_nxt;
  logic [LEVEL_BITS-1:0]         period_peak_r, period_peak_nxt;
  logic [LEVEL_BITS-1:0]         short_r;
  logic [LEVEL_BITS-1:0]         long_r;
  logic [LEVEL_BITS-1:0]         max_r;
  logic [spm_pkg::HITS_BITS-1:0] hits_r;

  logic [SAMPLE_BITS-1:0] neg;
  logic [LEVEL_BITS-1:0]  lvl;
  logic [LEVEL_BITS-1:0]  bp_cur;
  logic [LEVEL_BITS-1:0]  pp_cur;
  logic [PROD_BITS-1:0]   prod;
  logic [LEVEL_BITS-1:0]  decayed;

  always_comb begin
    neg = -sample;
    if (sample[SAMPLE_BITS-1]) begin
      lvl = neg[SAMPLE_BITS-1] ? LEVEL_MAX : neg[LEVEL_BITS-1:0];
    end else begin
      lvl = sample[LEVEL_BITS-1:0];
    end
    bp_cur  = (lvl > buffer_peak_r) ? lvl : buffer_peak_r;
    pp_cur  = (bp_cur > period_peak_r) ? bp_cur : period_peak_r;
    prod    = PROD_BITS'(long_r) * PROD_BITS'(decay_factor);
    decayed = prod[PROD_BITS-1:spm_pkg::DECAY_SHIFT];
  end

  always_comb begin
    buffer_peak_nxt = buffer_peak_r;
    period_peak_nxt = period_peak_r;
    short_nxt       = short_r;
    long_nxt        = long_r;
    max_nxt         = max_r;
    hits_nxt        = hits_r;
    hold_out        = hold_in;
    if (ctl.accept) begin
      buffer_peak_nxt = ctl.eob ? '0 : bp_cur;
      if (ctl.eob) begin
        period_peak_nxt = pp_cur;
        if (bp_cur > max_r) begin
          max_nxt  = bp_cur;
          hits_nxt = spm_pkg::HITS_BITS'(1);
        end else if (bp_cur == max_r && hits_r < spm_pkg::HITS_MAX) begin
          hits_nxt = hits_r + 1'b1;
        end
        if (ctl.publish) begin
          period_peak_nxt = '0;
          short_nxt       = pp_cur;
          if (pp_cur >= long_r) begin
            long_nxt = pp_cur;
            hold_out = '0;
          end else if (CMP_BITS'(hold_in) >= CMP_BITS'(hold_periods)) begin
            long_nxt = decayed;
          end else begin
            hold_out = hold_in + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_peak_r <= '0;
      period_peak_r <= '0;
      short_r       <= '0;
      long_r        <= '0;
      max_r         <= '0;
      hits_r        <= '0;
    end else begin
      buffer_peak_r <= buffer_peak_nxt;
      period_peak_r <= period_peak_nxt;
      short_r       <= short_nxt;
      long_r        <= long_nxt;
      max_r         <= max_nxt;
      hits_r        <= hits_nxt;
    end
  end

endmodule

### src/stereo_peak_hold_meter_core.sv
`timescale 1ns / 1ps
// A word with end_of_buffer set shows its result on out_* in the cycle after acceptance.
// Throughput: one word per clock while in_stall is low; both channel lanes update all levels together,
// the decay multiply being the longest path.
// in_stall rises only while the output register holds a result and out_stall is high.
// Reset (synchronous, rst_n low) clears all lane levels, counters and the output valid,
// and loads the registers with 8, 8 and 29491.

module stereo_peak_hold_meter_core #(
  parameter int SAMPLE_BITS  = spm_pkg::SAMPLE_BITS_DEF,
  parameter int COUNTER_BITS = spm_pkg::COUNTER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [spm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [spm_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]        in_right_sample,
  input  logic                                 in_end_of_buffer,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [SAMPLE_BITS-2:0]               out_short_level_left,
  output logic [SAMPLE_BITS-2:0]               out_short_level_right,
  output logic [SAMPLE_BITS-2:0]               out_long_level_left,
  output logic [SAMPLE_BITS-2:0]               out_long_level_right,
  output logic [SAMPLE_BITS-2:0]               out_max_level_left,
  output logic [SAMPLE_BITS-2:0]               out_max_level_right,
  output logic [spm_pkg::HITS_BITS-1:0]        out_max_hits_left,
  output logic [spm_pkg::HITS_BITS-1:0]        out_max_hits_right
);

  localparam int LEVEL_BITS = SAMPLE_BITS - 1;
  localparam int CMP_BITS   = (COUNTER_BITS > spm_pkg::CFG_BITS) ? COUNTER_BITS
                                                                 : spm_pkg::CFG_BITS;

  logic [spm_pkg::CFG_BITS-1:0]   short_period_r;
  logic [spm_pkg::CFG_BITS-1:0]   hold_periods_r;
  logic [spm_pkg::DECAY_BITS-1:0] decay_factor_r;

  logic [COUNTER_BITS-1:0] buffer_count_r, buffer_count_nxt;
  logic [COUNTER_BITS-1:0] hold_count_r, hold_count_nxt;
  logic [COUNTER_BITS-1:0] count_inc;
  logic [COUNTER_BITS-1:0] hold_mid;
  logic [COUNTER_BITS-1:0] hold_mid_l;

  logic                    accept;
  spm_pkg::lane_ctl_t      ctl;

  logic [LEVEL_BITS-1:0]         short_l, short_rt, long_l, long_rt, max_l, max_rt;
  logic [spm_pkg::HITS_BITS-1:0] hits_l, hits_rt;

  logic out_valid_r, out_valid_nxt;
  logic [LEVEL_BITS-1:0]         short_l_r, short_rt_r, long_l_r, long_rt_r;
  logic [LEVEL_BITS-1:0]         max_l_r, max_rt_r;
  logic [spm_pkg::HITS_BITS-1:0] hits_l_r, hits_rt_r;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign count_inc = buffer_count_r + 1'b1;

  always_comb begin
    ctl.accept  = accept;
    ctl.eob     = in_end_of_buffer;
    ctl.publish = in_end_of_buffer &
                  (CMP_BITS'(count_inc) >= CMP_BITS'(short_period_r));
  end

  always_comb begin
    buffer_count_nxt = buffer_count_r;
    hold_count_nxt   = hold_count_r;
    if (accept && in_end_of_buffer) begin
      buffer_count_nxt = ctl.publish ? '0 : count_inc;
      hold_count_nxt   = hold_mid;
    end
  end

  spm_lane #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_lane_left (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sample       (in_left_sample),
    .decay_factor (decay_factor_r),
    .hold_periods (hold_periods_r),
    .hold_in      (hold_count_r),
    .hold_out     (hold_mid_l),
    .short_nxt    (short_l),
    .long_nxt     (long_l),
    .max_nxt      (max_l),
    .hits_nxt     (hits_l)
  );

  spm_lane #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_lane_right (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sample       (in_right_sample),
    .decay_factor (decay_factor_r),
    .hold_periods (hold_periods_r),
    .hold_in      (hold_mid_l),
    .hold_out     (hold_mid),
    .short_nxt    (short_rt),
    .long_nxt     (long_rt),
    .max_nxt      (max_rt),
    .hits_nxt     (hits_rt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_period_r <= spm_pkg::SHORT_PERIOD_RST;
      hold_periods_r <= spm_pkg::HOLD_PERIODS_RST;
      decay_factor_r <= spm_pkg::DECAY_FACTOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spm_pkg::CFG_SHORT_PERIOD: short_period_r <= cfg_wdata;
        spm_pkg::CFG_HOLD_PERIODS: hold_periods_r <= cfg_wdata;
        spm_pkg::CFG_DECAY_FACTOR: decay_factor_r <= cfg_wdata[spm_pkg::DECAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_count_r <= '0;
      hold_count_r   <= '0;
    end else begin
      buffer_count_r <= buffer_count_nxt;
      hold_count_r   <= hold_count_nxt;
    end
  end

  assign out_valid_nxt = (accept & in_end_of_buffer) | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the result word
  always_ff @(posedge clk) begin
    if (accept && in_end_of_buffer) begin
      short_l_r  <= short_l;
      short_rt_r <= short_rt;
      long_l_r   <= long_l;
      long_rt_r  <= long_rt;
      max_l_r    <= max_l;
      max_rt_r   <= max_rt;
      hits_l_r   <= hits_l;
      hits_rt_r  <= hits_rt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_short_level_left  = short_l_r;
  assign out_short_level_right = short_rt_r;
  assign out_long_level_left   = long_l_r;
  assign out_long_level_right  = long_rt_r;
  assign out_max_level_left    = max_l_r;
  assign out_max_level_right   = max_rt_r;
  assign out_max_hits_left     = hits_l_r;
  assign out_max_hits_right    = hits_rt_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_buffer |=> out_valid)
    else $error("result word missing after end of buffer");

  a_hits_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_max_hits_left != '0) && (out_max_hits_right != '0))
    else $error("hit count zero in a result word");

  a_short_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_short_level_left <= out_max_level_left) &&
                  (out_short_level_right <= out_max_level_right))
    else $error("short level above maximum");

endmodule

### bench/tb_stereo_peak_hold_meter_core.sv
`timescale 1ns / 1ps

module tb_stereo_peak_hold_meter_core;
  import spm_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  localparam logic [CFG_BITS-1:0] PERIOD_SET [4] = '{16'd1, 16'd3, 16'd0, 16'd8};
  localparam logic [CFG_BITS-1:0] HOLD_SET   [4] = '{16'd2, 16'd0, 16'd5, 16'd8};
  localparam logic [CFG_BITS-1:0] DECAY_SET  [4] = '{16'd16384, 16'd32767, 16'd0, 16'd29491};

  typedef enum int {
    SHORT_L, SHORT_R, LONG_L, LONG_R, MAX_L, MAX_R, HITS_L, HITS_R, NUM_FIELDS
  } level_field_e;

  typedef logic [NUM_FIELDS-1:0][14:0] meter_word_t;

  class meter_scoreboard;
    logic [15:0] period_len, hold_len, buf_cnt, hold_cnt;
    logic [14:0] decay_q15;
    logic [14:0] buf_pk [2];
    logic [14:0] per_pk [2];
    logic [14:0] short_lv [2];
    logic [14:0] long_lv [2];
    logic [14:0] max_lv [2];
    logic [14:0] hits [2];
    meter_word_t expected_q [$];
    int faults;

    function new();
      period_len = SHORT_PERIOD_RST;
      hold_len   = HOLD_PERIODS_RST;
      decay_q15  = DECAY_FACTOR_RST;
      buf_cnt    = '0;
      hold_cnt   = '0;
      faults     = 0;
      for (int ch = 0; ch < 2; ch++) begin
        buf_pk[ch]   = '0;
        per_pk[ch]   = '0;
        short_lv[ch] = '0;
        long_lv[ch]  = '0;
        max_lv[ch]   = '0;
        hits[ch]     = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      case (idx)
        CFG_SHORT_PERIOD: period_len = val;
        CFG_HOLD_PERIODS: hold_len = val;
        CFG_DECAY_FACTOR: decay_q15 = val[DECAY_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [14:0] magnitude(logic signed [15:0] s);
      if (s == 16'sh8000) return 15'h7fff;
      return (s < 0) ? 15'(-s) : 15'(s);
    endfunction

    function void note_frame(logic signed [15:0] left, logic signed [15:0] right, logic eob);
      logic [14:0] lvl [2];
      logic [14:0] x;
      logic [29:0] prod;
      meter_word_t w;
      lvl[0] = magnitude(left);
      lvl[1] = magnitude(right);
      for (int ch = 0; ch < 2; ch++)
        if (lvl[ch] > buf_pk[ch]) buf_pk[ch] = lvl[ch];
      if (!eob) return;
      for (int ch = 0; ch < 2; ch++) begin
        x = buf_pk[ch];
        if (x > per_pk[ch]) per_pk[ch] = x;
        if (x > max_lv[ch]) begin
          max_lv[ch] = x;
          hits[ch] = 15'd1;
        end else if (x == max_lv[ch] && hits[ch] != HITS_MAX) begin
          hits[ch] = hits[ch] + 15'd1;
        end
        buf_pk[ch] = '0;
      end
      buf_cnt = buf_cnt + 16'd1;
      if (buf_cnt >= period_len) begin
        for (int ch = 0; ch < 2; ch++) begin
          x = per_pk[ch];
          short_lv[ch] = x;
          if (x >= long_lv[ch]) begin
            long_lv[ch] = x;
            hold_cnt = '0;
          end else if (hold_cnt >= hold_len) begin
            prod = long_lv[ch] * decay_q15;
            long_lv[ch] = prod[29:15];
          end else begin
            hold_cnt = hold_cnt + 16'd1;
          end
          per_pk[ch] = '0;
        end
        buf_cnt = '0;
      end
      w[SHORT_L] = short_lv[0];
      w[SHORT_R] = short_lv[1];
      w[LONG_L]  = long_lv[0];
      w[LONG_R]  = long_lv[1];
      w[MAX_L]   = max_lv[0];
      w[MAX_R]   = max_lv[1];
      w[HITS_L]  = hits[0];
      w[HITS_R]  = hits[1];
      expected_q.push_back(w);
    endfunction

    function void check_word(meter_word_t got);
      meter_word_t want;
      level_field_e fld;
      if (expected_q.size() == 0) begin
        faults++;
        if (faults <= 10) $display("%0t: result word %h with none expected", $time, got);
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < NUM_FIELDS; i++) begin
        fld = level_field_e'(i);
        if (got[i] !== want[i]) begin
          faults++;
          if (faults <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, fld.name(), want[i], got[i]);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_SHORT_PERIOD;
  logic [CFG_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_left_sample = '0;
  logic signed [15:0] in_right_sample = '0;
  logic in_end_of_buffer = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] out_short_level_left, out_short_level_right;
  logic [14:0] out_long_level_left, out_long_level_right;
  logic [14:0] out_max_level_left, out_max_level_right;
  logic [14:0] out_max_hits_left, out_max_hits_right;

  meter_scoreboard sb = new();
  meter_word_t seen_word;
  int hold_off_cycles = 0;
  int rx_run = 0;
  bit rx_stalls = 1'b0;
  bit tx_gaps = 1'b0;

  stereo_peak_hold_meter_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_left_sample        (in_left_sample),
    .in_right_sample       (in_right_sample),
    .in_end_of_buffer      (in_end_of_buffer),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_short_level_left  (out_short_level_left),
    .out_short_level_right (out_short_level_right),
    .out_long_level_left   (out_long_level_left),
    .out_long_level_right  (out_long_level_right),
    .out_max_level_left    (out_max_level_left),
    .out_max_level_right   (out_max_level_right),
    .out_max_hits_left     (out_max_hits_left),
    .out_max_hits_right    (out_max_hits_right)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_frame(in_left_sample, in_right_sample, in_end_of_buffer);
    if (rst_n && out_valid && !out_stall) begin
      seen_word[SHORT_L] = out_short_level_left;
      seen_word[SHORT_R] = out_short_level_right;
      seen_word[LONG_L]  = out_long_level_left;
      seen_word[LONG_R]  = out_long_level_right;
      seen_word[MAX_L]   = out_max_level_left;
      seen_word[MAX_R]   = out_max_level_right;
      seen_word[HITS_L]  = out_max_hits_left;
      seen_word[HITS_R]  = out_max_hits_right;
      sb.check_word(seen_word);
    end
  end

  // hold off on request, else stay ready unless rx_stalls is set, then alternate ready and stalled runs
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (!rx_stalls) begin
      out_stall <= 1'b0;
    end else if (rx_run > 0) begin
      rx_run <= rx_run - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      rx_run <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b1;
      rx_run <= gap_len();
    end
  end

  task automatic send_frame(logic signed [15:0] left, logic signed [15:0] right, logic eob);
    int gap;
    gap = tx_gaps ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_left_sample   <= left;
    in_right_sample  <= right;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_buffer(int frames, int amp, bit broken);
    logic signed [15:0] smp [2];
    int mag;
    for (int f = 0; f < frames; f++) begin
      for (int ch = 0; ch < 2; ch++) begin
        if (amp >= 32767) begin
          smp[ch] = 16'($urandom);
        end else begin
          mag = $urandom_range(0, amp);
          smp[ch] = 16'($urandom_range(0, 1) ? -mag : mag);
        end
      end
      send_frame(smp[0], smp[1], f == frames - 1 && !broken);
    end
  endtask

  task automatic run_phase(int frames);
    int sent, len, amp, r;
    sent = 0;
    while (sent < frames) begin
      r = $urandom_range(0, 99);
      len = (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      r = $urandom_range(0, 99);
      if (r < 15) amp = 32767;
      else if (r < 50) amp = $urandom_range(0, 40);
      else amp = $urandom_range(0, 4000);
      send_buffer(len, amp, $urandom_range(0, 9) == 0);
      sent += len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(16'sd0, 16'sd0, 1'b1);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b1);
    send_frame(16'sh8000, 16'sh7fff, 1'b1);
    repeat (5) send_frame(16'sd5, -16'sd5, 1'b1);
    drain();

    write_reg(CFG_SHORT_PERIOD, 16'd0);
    write_reg(CFG_HOLD_PERIODS, 16'd0);
    write_reg(CFG_DECAY_FACTOR, 16'hffff);
    write_reg(CFG_SPARE, 16'h1234);
    send_frame(16'sd100, -16'sd200, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b1);
    drain();

    write_reg(CFG_DECAY_FACTOR, 16'd0);
    send_frame(16'sd3, -16'sd3, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b1);
    drain();

    write_reg(CFG_SHORT_PERIOD, 16'hffff);
    write_reg(CFG_HOLD_PERIODS, 16'hffff);
    write_reg(CFG_DECAY_FACTOR, 16'(DECAY_FACTOR_RST));
    repeat (4) send_frame(16'sd7, 16'sd8, 1'b1);
    drain();

    // shorten the period while buffers are counted
    write_reg(CFG_SHORT_PERIOD, 16'd2);
    send_frame(16'sd9, 16'sd9, 1'b1);
    send_frame(-16'sd9, -16'sd9, 1'b1);

    tx_gaps = 1'b1;
    rx_stalls <= 1'b1;
    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(CFG_SHORT_PERIOD, PERIOD_SET[p]);
      write_reg(CFG_HOLD_PERIODS, HOLD_SET[p]);
      write_reg(CFG_DECAY_FACTOR, DECAY_SET[p]);
      if (p == 3) begin
        tx_gaps = 1'b0;
        rx_stalls <= 1'b0;
      end
      run_phase(45);
      if (p == 1) begin
        hold_off_cycles <= 200;
        tx_gaps = 1'b0;
        repeat (12) send_frame(16'($urandom), 16'($urandom), 1'b1);
        tx_gaps = 1'b1;
      end
      if (p == 2) drain();
      if (p == 3) begin
        tx_gaps = 1'b1;
        rx_stalls <= 1'b1;
      end
      run_phase(45);
    end

    drain();
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
